// ===== rtl/core/ptd_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

	localparam int unsigned DEPTH_DEF     = 16;
	localparam logic [31:0] TICK_RATE_RST = 32'd268111856;
	localparam int unsigned DIV_STEPS     = 32;

	localparam logic [2:0] CMD_APPEND = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_LOCK   = 3'd2;
	localparam logic [2:0] CMD_UNLOCK = 3'd3;
	localparam logic [2:0] CMD_TICK   = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_DUE  = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	localparam logic [15:0] NO_ID = 16'd0;

	typedef struct packed {
		logic [15:0] id;
		logic [31:0] period;
		logic [63:0] last_run;
		logic        locked;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic sort;
		logic odd;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_WALK,
		S_FIN,
		S_SORT
	} state_t;

endpackage

// ===== rtl/core/ptd_cell.sv =====
// One table slot: rotates toward slot 0 or does a compare-exchange with its neighbor.
module ptd_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic               clk,
	input  ptd_pkg::cell_ctl_t ctl,
	input  logic               load,
	input  ptd_pkg::entry_t    load_data,
	input  logic               pair_ok,
	input  ptd_pkg::entry_t    right_in,
	input  ptd_pkg::entry_t    left_in,
	input  logic               left_swap,
	output ptd_pkg::entry_t    ent,
	output logic               swap_r
);

	localparam logic MY_ODD = 1'(CELL_IDX % 2);

	ptd_pkg::entry_t ent_q;

	assign ent = ent_q;

	// strict compare keeps equal periods in place (stable)
	assign swap_r = ctl.sort && (ctl.odd == MY_ODD) && pair_ok &&
		(ent_q.period > right_in.period);

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_data;
		end else if (ctl.shift || swap_r) begin
			ent_q <= right_in;
		end else if (left_swap) begin
			ent_q <= left_in;
		end
	end

endmodule

// ===== rtl/core/ptd_div.sv =====
// Restoring divider, one quotient bit per cycle: period = rate / frequency.
module ptd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [7:0]  rem_q;
	logic [7:0]  dvs_q;
	logic [31:0] quo_q;
	logic [8:0]  trial;
	logic [8:0]  diff;
	logic        ge;

	assign trial    = {rem_q, quo_q[31]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ptd_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], ge};
			rem_q <= ge ? diff[7:0] : trial[7:0];
		end
	end

endmodule

// ===== rtl/core/periodic_task_dispatcher.sv =====
// Periodic task dispatcher top level: command sequencer over a ring of table cells.
// A command is taken when start is high and busy low. Results come one word per
// cycle on strobe and cannot be held off. Append with a bad frequency or a full
// table, and unknown command codes, answer the cycle after start and leave busy
// low. A valid append runs the divider. Delete, lock, unlock and an ordinary tick
// rotate the whole ring of TABLE_DEPTH cells once, one slot per cycle; due task
// ids leave during that rotation. The first tick after the table changed answers
// at once and then sorts by odd-even exchange between neighbor cells.
module periodic_task_dispatcher #(
	parameter int unsigned TABLE_DEPTH = ptd_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [15:0] task_id,
	input  logic [7:0]  frequency,
	input  logic [63:0] cur_tick,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [15:0] result_id,
	output logic        last,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	ptd_pkg::state_t state_q, state_d;

	logic [CW-1:0]   count_q;
	logic [15:0]     next_id_q;
	logic            altered_q;
	logic [31:0]     rate_q;
	logic [2:0]      cmd_q;
	logic [15:0]     tid_q;
	logic [63:0]     now_q;
	logic [IW-1:0]   step_q;
	logic            found_q;
	logic [IW-1:0]   slot_q;
	ptd_pkg::entry_t last_ent_q;
	logic            pend_q;
	logic [15:0]     pend_id_q;
	logic            strobe_q;
	logic [1:0]      status_q;
	logic [15:0]     rid_q;
	logic            last_q;

	ptd_pkg::entry_t    cell_ent [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] swap_r;
	ptd_pkg::cell_ctl_t ctl;
	ptd_pkg::entry_t    head;
	ptd_pkg::entry_t    fb;
	ptd_pkg::entry_t    load_data;
	logic               load_go;
	logic [IW-1:0]      load_idx;
	logic               emit;
	logic [1:0]         e_status;
	logic [15:0]        e_id;
	logic               e_last;
	logic               div_start;
	logic               div_done;
	logic [31:0]        div_quo;
	logic               accept;
	logic               app_bad;
	logic               in_range;
	logic               is_last_ent;
	logic               due;
	logic               match;
	logic               walk_end;
	logic [15:0]        next_id_inc;

	assign head        = cell_ent[0];
	assign accept      = start && (state_q == ptd_pkg::S_IDLE);
	assign app_bad     = (frequency == 8'd0) || (count_q >= CW'(TABLE_DEPTH));
	assign in_range    = CW'(step_q) < count_q;
	assign is_last_ent = CW'(step_q) == (count_q - CW'(1));
	assign due         = in_range && !head.locked &&
		((now_q - head.last_run) >= {32'd0, head.period});
	assign match       = in_range && (head.id == tid_q) && !found_q;
	assign walk_end    = step_q == IW'(TABLE_DEPTH - 1);
	assign next_id_inc = (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;

	assign busy      = state_q != ptd_pkg::S_IDLE;
	assign strobe    = strobe_q;
	assign status    = status_q;
	assign result_id = rid_q;
	assign last      = last_q;

	ptd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rate_q),
		.divisor  (frequency),
		.done     (div_done),
		.quotient (div_quo)
	);

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		ptd_pkg::entry_t r_in;
		ptd_pkg::entry_t l_in;
		logic            l_swap;
		logic            pair_ok;
		logic            ld;

		if (k == TABLE_DEPTH - 1) begin : g_tail
			assign r_in = fb;
		end else begin : g_mid
			assign r_in = cell_ent[k+1];
		end
		if (k == 0) begin : g_head
			assign l_in   = '0;
			assign l_swap = 1'b0;
		end else begin : g_body
			assign l_in   = cell_ent[k-1];
			assign l_swap = swap_r[k-1];
		end
		assign pair_ok = {1'b0, count_q} > (CW+1)'(k + 1);
		assign ld      = load_go && (load_idx == IW'(k));

		ptd_cell #(
			.CELL_IDX (k)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load      (ld),
			.load_data (load_data),
			.pair_ok   (pair_ok),
			.right_in  (r_in),
			.left_in   (l_in),
			.left_swap (l_swap),
			.ent       (cell_ent[k]),
			.swap_r    (swap_r[k])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptd_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd)
						ptd_pkg::CMD_APPEND:
							state_d = app_bad ? ptd_pkg::S_IDLE : ptd_pkg::S_DIV;
						ptd_pkg::CMD_DELETE, ptd_pkg::CMD_LOCK, ptd_pkg::CMD_UNLOCK:
							state_d = ptd_pkg::S_WALK;
						ptd_pkg::CMD_TICK:
							state_d = altered_q ? ptd_pkg::S_SORT : ptd_pkg::S_WALK;
						default: state_d = ptd_pkg::S_IDLE;
					endcase
				end
			end
			ptd_pkg::S_DIV:  if (div_done) state_d = ptd_pkg::S_IDLE;
			ptd_pkg::S_WALK: if (walk_end) state_d = ptd_pkg::S_FIN;
			ptd_pkg::S_FIN:  state_d = ptd_pkg::S_IDLE;
			ptd_pkg::S_SORT: if (walk_end) state_d = ptd_pkg::S_IDLE;
			default:         state_d = ptd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		fb        = head;
		load_go   = 1'b0;
		load_idx  = count_q[IW-1:0];
		load_data = '{id: next_id_q, period: div_quo, last_run: now_q, locked: 1'b0};
		emit      = 1'b0;
		e_status  = ptd_pkg::ST_FAIL;
		e_id      = tid_q;
		e_last    = 1'b1;
		div_start = 1'b0;
		unique case (state_q)
			ptd_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd)
						ptd_pkg::CMD_APPEND: begin
							if (app_bad) begin
								emit = 1'b1;
								e_id = ptd_pkg::NO_ID;
							end else begin
								div_start = 1'b1;
							end
						end
						ptd_pkg::CMD_DELETE, ptd_pkg::CMD_LOCK, ptd_pkg::CMD_UNLOCK: ;
						ptd_pkg::CMD_TICK: begin
							if (altered_q) begin
								emit     = 1'b1;
								e_status = ptd_pkg::ST_NONE;
								e_id     = ptd_pkg::NO_ID;
							end
						end
						default: begin
							emit = 1'b1;
							e_id = task_id;
						end
					endcase
				end
			end
			ptd_pkg::S_DIV: begin
				if (div_done) begin
					load_go  = 1'b1;
					emit     = 1'b1;
					e_status = ptd_pkg::ST_OK;
					e_id     = next_id_q;
				end
			end
			ptd_pkg::S_WALK: begin
				ctl.shift = 1'b1;
				if (cmd_q == ptd_pkg::CMD_TICK) begin
					if (due) begin
						fb.last_run = now_q;
						// a later due task exists, so the held one is not last
						if (pend_q) begin
							emit     = 1'b1;
							e_status = ptd_pkg::ST_DUE;
							e_id     = pend_id_q;
							e_last   = 1'b0;
						end
					end
				end else if ((cmd_q == ptd_pkg::CMD_LOCK ||
					cmd_q == ptd_pkg::CMD_UNLOCK) && match) begin
					fb.locked = cmd_q == ptd_pkg::CMD_LOCK;
				end
			end
			ptd_pkg::S_FIN: begin
				emit = 1'b1;
				if (cmd_q == ptd_pkg::CMD_TICK) begin
					e_status = pend_q ? ptd_pkg::ST_DUE : ptd_pkg::ST_NONE;
					e_id     = pend_q ? pend_id_q : ptd_pkg::NO_ID;
				end else begin
					e_status = found_q ? ptd_pkg::ST_OK : ptd_pkg::ST_FAIL;
					if (cmd_q == ptd_pkg::CMD_DELETE && found_q) begin
						load_go   = 1'b1;
						load_idx  = slot_q;
						load_data = last_ent_q;
					end
				end
			end
			ptd_pkg::S_SORT: begin
				ctl.sort = 1'b1;
				ctl.odd  = step_q[0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ptd_pkg::S_IDLE;
			count_q   <= '0;
			next_id_q <= 16'd1;
			altered_q <= 1'b0;
			rate_q    <= ptd_pkg::TICK_RATE_RST;
			step_q    <= '0;
			found_q   <= 1'b0;
			pend_q    <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			unique case (state_q)
				ptd_pkg::S_IDLE: begin
					step_q  <= '0;
					found_q <= 1'b0;
					pend_q  <= 1'b0;
					if (accept && cmd == ptd_pkg::CMD_TICK && altered_q) begin
						altered_q <= 1'b0;
					end
				end
				ptd_pkg::S_DIV: begin
					if (div_done) begin
						count_q   <= count_q + CW'(1);
						next_id_q <= next_id_inc;
						altered_q <= 1'b1;
					end
				end
				ptd_pkg::S_WALK, ptd_pkg::S_SORT: begin
					step_q <= walk_end ? '0 : step_q + IW'(1);
					if (state_q == ptd_pkg::S_WALK) begin
						if (cmd_q == ptd_pkg::CMD_TICK) begin
							if (due) pend_q <= 1'b1;
						end else if (match) begin
							found_q <= 1'b1;
						end
					end
				end
				ptd_pkg::S_FIN: begin
					if (cmd_q == ptd_pkg::CMD_DELETE && found_q) begin
						count_q   <= count_q - CW'(1);
						altered_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			tid_q <= task_id;
			now_q <= cur_tick;
		end
		if (state_q == ptd_pkg::S_WALK) begin
			if (match) slot_q <= step_q;
			if (cmd_q == ptd_pkg::CMD_DELETE && in_range && is_last_ent) last_ent_q <= head;
			if (cmd_q == ptd_pkg::CMD_TICK && due) pend_id_q <= head.id;
		end
		if (emit) begin
			status_q <= e_status;
			rid_q    <= e_id;
			last_q   <= e_last;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != 16'd0)
		else $error("next task id is zero");

	a_altered_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == ptd_pkg::CMD_TICK && altered_q |=>
		strobe && status == ptd_pkg::ST_NONE && last && !altered_q)
		else $error("tick on altered table did not answer none");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptd_pkg::S_DIV && div_done |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not grow the table");

	a_busy_no_strobe_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptd_pkg::S_WALK && cmd_q != ptd_pkg::CMD_TICK |=> !strobe)
		else $error("word emitted mid-walk for a non-tick command");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for the periodic task dispatcher: directed and random commands checked word by word.
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH       = ptd_pkg::DEPTH_DEF;
	localparam int IDLE_LIMIT  = 3000;
	localparam int SETTLE      = 40;
	localparam logic [2:0] CMD_BAD_LO = 3'd5;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] id;
		logic        last;
	} word_t;

	logic        clk, arst_n, start, busy, strobe, last, cfg_we;
	logic [2:0]  cmd;
	logic [15:0] task_id, result_id;
	logic [7:0]  frequency;
	logic [63:0] cur_tick;
	logic [1:0]  status;
	logic [31:0] cfg_wdata;

	periodic_task_dispatcher uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.task_id(task_id), .frequency(frequency), .cur_tick(cur_tick),
		.strobe(strobe), .status(status), .result_id(result_id), .last(last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// shadow of the task table
	logic [15:0] tbl_id[DEPTH];
	logic [31:0] tbl_period[DEPTH];
	logic [63:0] tbl_last_run[DEPTH];
	logic        tbl_locked[DEPTH];
	int          tbl_count;
	logic [15:0] next_id;
	logic        tbl_dirty;
	logic [31:0] rate;

	word_t       pending_words[$];
	int          errors;
	int          idle_cycles;
	logic [63:0] sys_now;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int slot_of(logic [15:0] id);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	task automatic push_word(logic [1:0] st, logic [15:0] id, logic fin);
		word_t w;
		w.status = st;
		w.id = id;
		w.last = fin;
		pending_words.push_back(w);
	endtask

	task automatic dispatch_model(logic [2:0] c, logic [15:0] id, logic [7:0] f,
		logic [63:0] t);
		int s, n;
		logic [15:0] kid;
		logic [31:0] kper;
		logic [63:0] klr;
		logic        klk;
		int j;
		case (c)
			ptd_pkg::CMD_APPEND: begin
				if (f == 0 || tbl_count >= DEPTH) begin
					push_word(ptd_pkg::ST_FAIL, ptd_pkg::NO_ID, 1'b1);
				end else begin
					tbl_id[tbl_count] = next_id;
					tbl_period[tbl_count] = rate / {24'd0, f};
					tbl_last_run[tbl_count] = t;
					tbl_locked[tbl_count] = 1'b0;
					push_word(ptd_pkg::ST_OK, next_id, 1'b1);
					next_id = next_id + 16'd1;
					if (next_id == 0) next_id = 16'd1;
					tbl_count++;
					tbl_dirty = 1'b1;
				end
			end
			ptd_pkg::CMD_DELETE: begin
				s = slot_of(id);
				if (s < 0) begin
					push_word(ptd_pkg::ST_FAIL, id, 1'b1);
				end else begin
					tbl_id[s] = tbl_id[tbl_count-1];
					tbl_period[s] = tbl_period[tbl_count-1];
					tbl_last_run[s] = tbl_last_run[tbl_count-1];
					tbl_locked[s] = tbl_locked[tbl_count-1];
					tbl_count--;
					tbl_dirty = 1'b1;
					push_word(ptd_pkg::ST_OK, id, 1'b1);
				end
			end
			ptd_pkg::CMD_LOCK, ptd_pkg::CMD_UNLOCK: begin
				s = slot_of(id);
				if (s < 0) begin
					push_word(ptd_pkg::ST_FAIL, id, 1'b1);
				end else begin
					tbl_locked[s] = (c == ptd_pkg::CMD_LOCK);
					push_word(ptd_pkg::ST_OK, id, 1'b1);
				end
			end
			ptd_pkg::CMD_TICK: begin
				if (tbl_dirty) begin
					// stable insertion sort by period
					for (int i = 1; i < tbl_count; i++) begin
						kid = tbl_id[i]; kper = tbl_period[i];
						klr = tbl_last_run[i]; klk = tbl_locked[i];
						j = i;
						while (j > 0 && tbl_period[j-1] > kper) begin
							tbl_id[j] = tbl_id[j-1]; tbl_period[j] = tbl_period[j-1];
							tbl_last_run[j] = tbl_last_run[j-1]; tbl_locked[j] = tbl_locked[j-1];
							j--;
						end
						tbl_id[j] = kid; tbl_period[j] = kper;
						tbl_last_run[j] = klr; tbl_locked[j] = klk;
					end
					tbl_dirty = 1'b0;
					push_word(ptd_pkg::ST_NONE, ptd_pkg::NO_ID, 1'b1);
				end else begin
					n = 0;
					for (int i = 0; i < tbl_count; i++) begin
						if (!tbl_locked[i] &&
							(t - tbl_last_run[i]) >= {32'd0, tbl_period[i]}) begin
							tbl_last_run[i] = t;
							push_word(ptd_pkg::ST_DUE, tbl_id[i], 1'b0);
							n++;
						end
					end
					if (n == 0) push_word(ptd_pkg::ST_NONE, ptd_pkg::NO_ID, 1'b1);
					else pending_words[$].last = 1'b1;
				end
			end
			default: push_word(ptd_pkg::ST_FAIL, id, 1'b1);
		endcase
	endtask

	task automatic pause_sender();
		int r, n;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) return;
		n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 40);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// start may stay high on return; the caller sends again or drains in the same step
	task automatic send_word(logic [2:0] c, logic [15:0] id, logic [7:0] f, logic [63:0] t);
		start <= 1'b1;
		cmd <= c;
		task_id <= id;
		frequency <= f;
		cur_tick <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		dispatch_model(c, id, f, t);
		pause_sender();
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_rate(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate = v;
	endtask

	function automatic logic [15:0] pick_id();
		if (tbl_count > 0 && $urandom_range(0, 99) < 80)
			return tbl_id[$urandom_range(0, tbl_count - 1)];
		return 16'($urandom);
	endfunction

	function automatic logic [63:0] advance_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return sys_now + $urandom_range(0, 15);
		if (r < 92) return sys_now + 64'($urandom % ({1'b0, rate} / 2 + 2));
		return {$urandom, $urandom};
	endfunction

	task automatic random_word();
		int r;
		logic [2:0] c;
		r = $urandom_range(0, 99);
		if (r < 22) c = ptd_pkg::CMD_APPEND;
		else if (r < 40) c = ptd_pkg::CMD_DELETE;
		else if (r < 50) c = ptd_pkg::CMD_LOCK;
		else if (r < 60) c = ptd_pkg::CMD_UNLOCK;
		else if (r < 96) c = ptd_pkg::CMD_TICK;
		else c = 3'($urandom_range(CMD_BAD_LO, 7));
		sys_now = advance_time();
		send_word(c, pick_id(), ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom),
			sys_now);
	endtask

	task automatic test_directed();
		send_word(ptd_pkg::CMD_APPEND, 16'hFFFF, 8'd0, 64'd0);
		send_word(ptd_pkg::CMD_APPEND, 16'd0, 8'd255, 64'd0);
		send_word(ptd_pkg::CMD_APPEND, 16'd0, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(ptd_pkg::CMD_APPEND, 16'd0, 8'd128, 64'd10);
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'd20);
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'd21);
		send_word(ptd_pkg::CMD_LOCK, 16'd1, 8'd0, 64'd0);
		send_word(ptd_pkg::CMD_LOCK, 16'hBEEF, 8'd0, 64'd0);
		send_word(ptd_pkg::CMD_UNLOCK, 16'h4141, 8'd0, 64'd0);
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'h0000_0000_7FFF_FFFF);
		send_word(ptd_pkg::CMD_UNLOCK, 16'd1, 8'd0, 64'd0);
		// tick time crosses the 32-bit boundary
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'h0000_0001_0000_0000);
		send_word(ptd_pkg::CMD_DELETE, 16'h8000, 8'd0, 64'd0);
		send_word(ptd_pkg::CMD_DELETE, 16'd2, 8'd0, 64'd0);
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'd0);
		for (int k = 5; k <= 7; k++) send_word(3'(k), 16'h5AA5, 8'd3, 64'd0);
		repeat (15)
			send_word(ptd_pkg::CMD_APPEND, 16'd0, 8'($urandom_range(1, 255)), 64'd5);
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'd6);
		send_word(ptd_pkg::CMD_TICK, 16'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		drain();
	endtask

	task automatic test_random(logic [31:0] v, int count);
		write_rate(v);
		sys_now = {$urandom, $urandom};
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if (k == count / 2) drain();
			random_word();
		end
		no_idle = 1'b0;
		drain();
	endtask

	always @(posedge clk) begin
		word_t w;
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: status %0d id %0h last %0b", status, result_id, last);
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, status);
					errors++;
				end
				if (result_id !== w.id) begin
					$error("result_id: expected %0h, got %0h", w.id, result_id);
					errors++;
				end
				if (last !== w.last) begin
					$error("last: expected %0b, got %0b", w.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = ptd_pkg::CMD_TICK;
		task_id = '0;
		frequency = '0;
		cur_tick = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		errors = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		tbl_count = 0;
		next_id = 16'd1;
		tbl_dirty = 1'b0;
		rate = ptd_pkg::TICK_RATE_RST;
		sys_now = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(ptd_pkg::TICK_RATE_RST, 110);
		test_random(32'hFFFF_FFFF, 90);
		test_random(32'd0, 60);
		test_random(32'd1, 60);
		test_random(32'd1000 + $urandom_range(0, 5000), 120);
		drain();
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
